### hdl/bezier_path_flattener_unit_macros.svh
// assertion macros for the path flattener checker
// relies on clk and rst_n being visible where a macro is used
`ifndef BEZIER_PATH_FLATTENER_UNIT_MACROS_SVH
`define BEZIER_PATH_FLATTENER_UNIT_MACROS_SVH

// same-cycle implication, masked while in reset
`define BPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define BPF_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset cycles
`define BPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bpf_pkg.sv
// shared types and constants of the path flattener
// no dependencies
`default_nettype none

package bpf_pkg;

  // point and accumulator widths
  localparam int unsigned PT_W  = 24;
  localparam int unsigned ACC_W = 48;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned KIND_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_MOVE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LINE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_QUAD  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CUBIC = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLOSE = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSED = 2'd2;

  // horner step index within one coordinate
  localparam logic [1:0] STEP_A = 2'd0;
  localparam logic [1:0] STEP_B = 2'd1;
  localparam logic [1:0] STEP_C = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_MAC,
    ST_SAMPLE,
    ST_FLUSH,
    ST_MARK,
    ST_POINT
  } bpf_state_t;

endpackage

`default_nettype wire

### hdl/bezier_path_flattener_unit.sv
// Path flattener: one item at a time, in_ready high only when idle.
// Move/line/close: accept, then ST_MARK (closed marker) and/or ST_POINT (vertex) as needed;
// with no open contour, line, curve and close stop at the accept; unknown codes always do.
// Curves: accept, a coefficient state, then for each sample k = 1..SAMPLES-1 3 horner
// steps per coordinate plus a compare, then a flush; output back-pressure stalls these.
// Reset (rst_n low, synchronous) clears the state, contour flag and previous point.
`default_nettype none

module bezier_path_flattener_unit #(
  parameter int unsigned SAMPLES = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [bpf_pkg::REQ_W-1:0]   in_req_type,
  input  logic signed [bpf_pkg::PT_W-1:0]    in_ctrl_a_x,
  input  logic signed [bpf_pkg::PT_W-1:0]    in_ctrl_a_y,
  input  logic signed [bpf_pkg::PT_W-1:0]    in_ctrl_b_x,
  input  logic signed [bpf_pkg::PT_W-1:0]    in_ctrl_b_y,
  input  logic signed [bpf_pkg::PT_W-1:0]    in_end_x,
  input  logic signed [bpf_pkg::PT_W-1:0]    in_end_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [bpf_pkg::KIND_W-1:0]  out_kind,
  output logic signed [bpf_pkg::PT_W-1:0]    out_vertex_x,
  output logic signed [bpf_pkg::PT_W-1:0]    out_vertex_y,
  output logic                               out_last
);
  import bpf_pkg::*;

  localparam int unsigned LOG_N = $clog2(SAMPLES - 1);
  localparam int unsigned SH    = 3 * LOG_N;
  localparam int unsigned K_W   = $clog2(SAMPLES);
  localparam logic signed [ACC_W-1:0] V_MAX = ACC_W'((64'd1 << (PT_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] V_MIN = ~V_MAX;

  bpf_state_t state_r, state_nxt;

  // request registers
  logic [REQ_W-1:0]        req_r;
  logic signed [PT_W-1:0]  pa_x_r, pa_y_r, pb_x_r, pb_y_r, pe_x_r, pe_y_r;

  // architectural state
  logic signed [PT_W-1:0]  prev_x_r, prev_y_r;
  logic                    open_r;

  // sampling state
  logic signed [ACC_W-1:0] cax_r, cbx_r, ccx_r, cdx_r;
  logic signed [ACC_W-1:0] cay_r, cby_r, ccy_r, cdy_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [K_W-1:0]          k_r;
  logic [1:0]              step_r;
  logic                    coord_r;
  logic signed [PT_W-1:0]  sx_r, lx_r, ly_r, pend_x_r, pend_y_r;
  logic                    pend_valid_r;

  // output register
  logic                    out_valid_r;
  logic [KIND_W-1:0]       out_kind_r;
  logic signed [PT_W-1:0]  out_x_r, out_y_r;
  logic                    out_last_r;

  // combinational helpers
  logic                    accept, can_load, is_cubic, k_last, diff, stall;
  logic                    emit, emit_last;
  logic [KIND_W-1:0]       emit_kind;
  logic signed [PT_W-1:0]  emit_x, emit_y;
  logic signed [ACC_W-1:0] nax, nbx, ncx, ndx, nay, nby, ncy, ndy;
  logic signed [ACC_W-1:0] mac_opnd, mac_add, mac_res, shv;
  logic signed [PT_W-1:0]  cur_v;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;
  assign is_cubic = (req_r == REQ_CUBIC);
  assign k_last   = (k_r == K_W'(SAMPLES - 1));

  // coefficient lanes for x and y
  bpf_coef #(.LOG_N(LOG_N)) u_coef_x (
    .is_cubic (is_cubic),
    .p0       (prev_x_r),
    .pa       (pa_x_r),
    .pb       (pb_x_r),
    .pe       (pe_x_r),
    .ca       (nax),
    .cb       (nbx),
    .cc       (ncx),
    .cd       (ndx)
  );

  bpf_coef #(.LOG_N(LOG_N)) u_coef_y (
    .is_cubic (is_cubic),
    .p0       (prev_y_r),
    .pa       (pa_y_r),
    .pb       (pb_y_r),
    .pe       (pe_y_r),
    .ca       (nay),
    .cb       (nby),
    .cc       (ncy),
    .cd       (ndy)
  );

  // operand selection for the shared multiply-add
  always_comb begin
    mac_opnd = acc_r;
    case (step_r)
      STEP_A: begin
        mac_opnd = coord_r ? cay_r : cax_r;
        mac_add  = coord_r ? cby_r : cbx_r;
      end
      STEP_B: mac_add = coord_r ? ccy_r : ccx_r;
      STEP_C: mac_add = coord_r ? cdy_r : cdx_r;
      default: mac_add = '0;
    endcase
  end

  bpf_mac #(.K_W(K_W)) u_mac (
    .opnd   (mac_opnd),
    .mul_k  (k_r),
    .addend (mac_add),
    .res    (mac_res)
  );

  // round (half already added) and saturate the finished coordinate
  assign shv   = acc_r >>> SH;
  assign cur_v = (shv > V_MAX) ? V_MAX[PT_W-1:0] :
                 (shv < V_MIN) ? V_MIN[PT_W-1:0] : shv[PT_W-1:0];
  assign diff  = (sx_r != lx_r) || (cur_v != ly_r);
  assign stall = (state_r == ST_SAMPLE) && diff && pend_valid_r && !can_load;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_MOVE:  state_nxt = open_r ? ST_MARK : ST_POINT;
            REQ_LINE:  state_nxt = open_r ? ST_POINT : ST_IDLE;
            REQ_QUAD,
            REQ_CUBIC: state_nxt = open_r ? ST_COEF : ST_IDLE;
            REQ_CLOSE: state_nxt = open_r ? ST_MARK : ST_IDLE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_COEF: state_nxt = ST_MAC;
      ST_MAC: begin
        if (coord_r && (step_r == STEP_C)) state_nxt = ST_SAMPLE;
      end
      ST_SAMPLE: begin
        if (!stall) state_nxt = k_last ? ST_FLUSH : ST_MAC;
      end
      ST_FLUSH: begin
        if (!pend_valid_r || can_load) state_nxt = ST_IDLE;
      end
      ST_MARK: begin
        if (can_load) state_nxt = (req_r == REQ_CLOSE) ? ST_IDLE : ST_POINT;
      end
      ST_POINT: begin
        if (can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_VERTEX;
    emit_x    = pend_x_r;
    emit_y    = pend_y_r;
    emit_last = 1'b0;
    case (state_r)
      ST_SAMPLE: emit = diff && pend_valid_r && can_load;
      ST_FLUSH: begin
        emit      = pend_valid_r && can_load;
        emit_last = 1'b1;
      end
      ST_MARK: begin
        emit      = can_load;
        emit_kind = KIND_CLOSED;
        emit_x    = '0;
        emit_y    = '0;
        emit_last = (req_r == REQ_CLOSE);
      end
      ST_POINT: begin
        emit      = can_load;
        emit_kind = (req_r == REQ_MOVE) ? KIND_FIRST : KIND_VERTEX;
        emit_x    = pe_x_r;
        emit_y    = pe_y_r;
        emit_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      open_r       <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      k_r          <= '0;
      step_r       <= STEP_A;
      coord_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // output slot
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          // line or curve with no open contour only moves the pen
          if (accept && !open_r && ((in_req_type == REQ_LINE) ||
              (in_req_type == REQ_QUAD) || (in_req_type == REQ_CUBIC))) begin
            prev_x_r <= in_end_x;
            prev_y_r <= in_end_y;
          end
        end
        ST_COEF: begin
          k_r          <= K_W'(1);
          step_r       <= STEP_A;
          coord_r      <= 1'b0;
          pend_valid_r <= 1'b0;
        end
        ST_MAC: begin
          if (step_r == STEP_C) begin
            step_r  <= STEP_A;
            coord_r <= !coord_r;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        ST_SAMPLE: begin
          if (!stall) begin
            if (diff) pend_valid_r <= 1'b1;
            k_r <= k_r + K_W'(1);
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_r || can_load) begin
            pend_valid_r <= 1'b0;
            prev_x_r     <= pe_x_r;
            prev_y_r     <= pe_y_r;
          end
        end
        ST_MARK: begin
          if (can_load && (req_r == REQ_CLOSE)) begin
            open_r   <= 1'b0;
            prev_x_r <= '0;
            prev_y_r <= '0;
          end
        end
        ST_POINT: begin
          if (can_load) begin
            prev_x_r <= pe_x_r;
            prev_y_r <= pe_y_r;
            if (req_r == REQ_MOVE) open_r <= 1'b1;
          end
        end
        default: begin
          open_r <= open_r;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      pa_x_r <= in_ctrl_a_x;
      pa_y_r <= in_ctrl_a_y;
      pb_x_r <= in_ctrl_b_x;
      pb_y_r <= in_ctrl_b_y;
      pe_x_r <= in_end_x;
      pe_y_r <= in_end_y;
    end

    // coefficients and the starting sample
    if (state_r == ST_COEF) begin
      cax_r <= nax;
      cbx_r <= nbx;
      ccx_r <= ncx;
      cdx_r <= ndx;
      cay_r <= nay;
      cby_r <= nby;
      ccy_r <= ncy;
      cdy_r <= ndy;
      lx_r  <= prev_x_r;
      ly_r  <= prev_y_r;
    end

    // horner step; x result is taken as y starts
    if (state_r == ST_MAC) begin
      acc_r <= mac_res;
      if (coord_r && (step_r == STEP_A)) sx_r <= cur_v;
    end

    // new distinct sample becomes pending
    if ((state_r == ST_SAMPLE) && !stall && diff) begin
      pend_x_r <= sx_r;
      pend_y_r <= cur_v;
      lx_r     <= sx_r;
      ly_r     <= cur_v;
    end

    if (emit) begin
      out_kind_r <= emit_kind;
      out_x_r    <= emit_x;
      out_y_r    <= emit_y;
      out_last_r <= emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_vertex_x = out_x_r;
  assign out_vertex_y = out_y_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

### hdl/bpf_mac.sv
// shared multiply-add unit: res = opnd * k + addend
// depends on bpf_pkg
`default_nettype none

module bpf_mac #(
  parameter int unsigned K_W = 3
) (
  input  logic signed [bpf_pkg::ACC_W-1:0] opnd,
  input  logic        [K_W-1:0]            mul_k,
  input  logic signed [bpf_pkg::ACC_W-1:0] addend,
  output logic signed [bpf_pkg::ACC_W-1:0] res
);
  import bpf_pkg::*;

  logic signed [ACC_W+K_W:0] prod;

  // k is unsigned, so widen it with a zero sign bit
  assign prod = opnd * $signed({1'b0, mul_k});
  assign res  = prod[ACC_W-1:0] + addend;

endmodule

`default_nettype wire

### hdl/bpf_coef.sv
// power-basis coefficients of one coordinate, scaled to the cubic denominator
// depends on bpf_pkg
`default_nettype none

module bpf_coef #(
  parameter int unsigned LOG_N = 2
) (
  input  logic                             is_cubic,
  input  logic signed [bpf_pkg::PT_W-1:0]  p0,
  input  logic signed [bpf_pkg::PT_W-1:0]  pa,
  input  logic signed [bpf_pkg::PT_W-1:0]  pb,
  input  logic signed [bpf_pkg::PT_W-1:0]  pe,
  output logic signed [bpf_pkg::ACC_W-1:0] ca,
  output logic signed [bpf_pkg::ACC_W-1:0] cb,
  output logic signed [bpf_pkg::ACC_W-1:0] cc,
  output logic signed [bpf_pkg::ACC_W-1:0] cd
);
  import bpf_pkg::*;

  localparam int unsigned SH = 3 * LOG_N;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'((64'd1 << SH) >> 1);

  logic signed [ACC_W-1:0] e0, ea, eb, ee;
  logic signed [ACC_W-1:0] a_cub, t_cub, b_cub, u_dif, c_cub;
  logic signed [ACC_W-1:0] b_quad, c_quad;

  // sign extend the points
  assign e0 = ACC_W'(p0);
  assign ea = ACC_W'(pa);
  assign eb = ACC_W'(pb);
  assign ee = ACC_W'(pe);

  // cubic: a = pe - 3pb + 3pa - p0, b = 3(pb - 2pa + p0), c = 3(pa - p0)
  assign a_cub = ee - eb - (eb <<< 1) + ea + (ea <<< 1) - e0;
  assign t_cub = eb - (ea <<< 1) + e0;
  assign b_cub = t_cub + (t_cub <<< 1);
  assign u_dif = ea - e0;
  assign c_cub = u_dif + (u_dif <<< 1);

  // quadratic: b = pe - 2pa + p0, c = 2(pa - p0), one extra factor n on each term
  assign b_quad = ee - (ea <<< 1) + e0;
  assign c_quad = u_dif <<< 1;

  // horner form ((a k + b n) k + c n^2) k + p0 n^3 + rounding half
  assign ca = is_cubic ? a_cub : '0;
  assign cb = (is_cubic ? b_cub : b_quad) <<< LOG_N;
  assign cc = (is_cubic ? c_cub : c_quad) <<< (2 * LOG_N);
  assign cd = (e0 <<< SH) + HALF;

endmodule

`default_nettype wire

### hdl/bpf_checker.sv
// port-level checks of the path flattener result channel, bound to the top level
// depends on bpf_pkg and bezier_path_flattener_unit_macros.svh
`default_nettype none

`include "bezier_path_flattener_unit_macros.svh"

module bpf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic        [bpf_pkg::KIND_W-1:0]  out_kind,
  input logic signed [bpf_pkg::PT_W-1:0]    out_vertex_x,
  input logic signed [bpf_pkg::PT_W-1:0]    out_vertex_y,
  input logic                               out_last
);
  import bpf_pkg::*;

  // no result right after reset
  `BPF_ASSERT_NXT(a_rst_quiet, !rst_n, !out_valid, "result valid after reset")

  // only defined kinds leave the block
  `BPF_ASSERT_IMP(a_kind_ok, out_valid, (out_kind == KIND_VERTEX) || (out_kind == KIND_FIRST) || (out_kind == KIND_CLOSED), "undefined result kind")

  // closed marker carries a zero point
  `BPF_ASSERT_IMP(a_mark_zero, out_valid && (out_kind == KIND_CLOSED), (out_vertex_x == '0) && (out_vertex_y == '0), "closed marker with nonzero point")

  // first vertex of a contour always ends its request
  `BPF_ASSERT_IMP(a_first_last, out_valid && (out_kind == KIND_FIRST), out_last, "first vertex not flagged last")

  // stalled result holds
  `BPF_ASSERT_HOLD(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_vertex_x) && $stable(out_vertex_y) && $stable(out_last), "stalled result changed")

endmodule

bind bezier_path_flattener_unit bpf_checker u_bpf_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for bezier_path_flattener_unit: random path requests with
// a contour-tracking vertex predictor held in a small scoreboard class
// depends on bpf_pkg and the flattener rtl only

module testbench;
  import bpf_pkg::*;

  localparam int unsigned SAMPLES = 5;
  localparam int CLK_PERIOD = 12;
  localparam int TIMEOUT_CYCLES = 600_000;
  localparam int DRAIN_CYCLES = 48;
  localparam int MAX_REPORTS = 10;

  typedef logic [REQ_W-1:0] req_code_t;
  typedef logic signed [PT_W-1:0] coord_t;

  // request codes the block ignores
  localparam req_code_t REQ_FIRST_UNUSED = 3'd5;
  localparam req_code_t REQ_LAST_UNUSED = 3'd7;

  localparam coord_t PT_MAX = 24'sh7fffff;
  localparam coord_t PT_MIN = 24'sh800000;

  typedef struct packed {
    req_code_t req_type;
    coord_t    ctrl_a_x;
    coord_t    ctrl_a_y;
    coord_t    ctrl_b_x;
    coord_t    ctrl_b_y;
    coord_t    end_x;
    coord_t    end_y;
  } path_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    coord_t            x;
    coord_t            y;
    logic              last;
  } vertex_t;

  // contour tracker and expected vertex store
  class vertex_scoreboard;
    vertex_t expected_vertices[$];
    coord_t  prev_x = '0;
    coord_t  prev_y = '0;
    bit      contour_open = 1'b0;
    int      errors = 0;

    function void log_failure(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
    endfunction

    function void push_vertex(logic [KIND_W-1:0] kind, coord_t x, coord_t y);
      vertex_t v;
      v.kind = kind;
      v.x = x;
      v.y = y;
      v.last = 1'b0;
      expected_vertices.push_back(v);
    endfunction

    // round num/den to nearest, ties toward plus infinity, den > 0
    function longint round_ratio(longint num, longint den);
      longint n2, d2, q;
      n2 = 2 * num + den;
      d2 = 2 * den;
      q = n2 / d2;
      if ((n2 % d2) != 0 && n2 < 0) q--;
      return q;
    endfunction

    // one coordinate of the power-basis curve at t = k/(SAMPLES-1)
    function coord_t curve_coord(bit is_cubic, longint p0, longint pa, longint pb,
                                 longint pe, longint k);
      longint n, ca, cb, cc, num, den, v;
      n = SAMPLES - 1;
      if (is_cubic) begin
        cc = 3 * (pa - p0);
        cb = 3 * pb - 6 * pa + 3 * p0;
        ca = pe - 3 * pb + 3 * pa - p0;
        num = ca * k * k * k + cb * k * k * n + cc * k * n * n + p0 * n * n * n;
        den = n * n * n;
      end else begin
        cc = 2 * (pa - p0);
        cb = pe - 2 * pa + p0;
        num = cb * k * k + cc * k * n + p0 * n * n;
        den = n * n;
      end
      v = round_ratio(num, den);
      if (v > PT_MAX) v = PT_MAX;
      if (v < PT_MIN) v = PT_MIN;
      return coord_t'(v);
    endfunction

    // work out the vertices caused by one accepted request
    function void note_request(path_req_t r);
      coord_t  smp_x, smp_y, last_x, last_y;
      int      start_size;
      int      k;
      bit      is_cubic;
      vertex_t tail;
      start_size = expected_vertices.size();
      case (r.req_type)
        REQ_MOVE: begin
          if (contour_open) push_vertex(KIND_CLOSED, '0, '0);
          contour_open = 1'b1;
          prev_x = r.end_x;
          prev_y = r.end_y;
          push_vertex(KIND_FIRST, r.end_x, r.end_y);
        end
        REQ_LINE: begin
          if (contour_open) push_vertex(KIND_VERTEX, r.end_x, r.end_y);
          prev_x = r.end_x;
          prev_y = r.end_y;
        end
        REQ_QUAD, REQ_CUBIC: begin
          is_cubic = (r.req_type == REQ_CUBIC);
          last_x = prev_x;
          last_y = prev_y;
          for (k = 0; k < SAMPLES; k++) begin
            smp_x = curve_coord(is_cubic, prev_x, r.ctrl_a_x, r.ctrl_b_x, r.end_x, k);
            smp_y = curve_coord(is_cubic, prev_y, r.ctrl_a_y, r.ctrl_b_y, r.end_y, k);
            // repeated samples are dropped
            if (smp_x != last_x || smp_y != last_y) begin
              last_x = smp_x;
              last_y = smp_y;
              if (contour_open) push_vertex(KIND_VERTEX, smp_x, smp_y);
            end
          end
          prev_x = r.end_x;
          prev_y = r.end_y;
        end
        REQ_CLOSE: begin
          if (contour_open) begin
            push_vertex(KIND_CLOSED, '0, '0);
            contour_open = 1'b0;
            prev_x = '0;
            prev_y = '0;
          end
        end
        default: ;
      endcase
      // flag the final vertex of this request
      if (expected_vertices.size() > start_size) begin
        tail = expected_vertices.pop_back();
        tail.last = 1'b1;
        expected_vertices.push_back(tail);
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (expected_vertices.size() == 0) begin
        log_failure($sformatf("unexpected vertex kind=%0d x=%0d y=%0d last=%0b",
                              got.kind, got.x, got.y, got.last));
      end else begin
        want = expected_vertices.pop_front();
        if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
            got.last !== want.last) begin
          log_failure($sformatf(
            "vertex mismatch: exp kind=%0d x=%0d y=%0d last=%0b, got kind=%0d x=%0d y=%0d last=%0b",
            want.kind, want.x, want.y, want.last, got.kind, got.x, got.y, got.last));
        end
      end
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction

    function void check_leftover();
      if (expected_vertices.size() != 0)
        log_failure($sformatf("%0d expected vertices never arrived", expected_vertices.size()));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  req_code_t in_req_type = '0;
  coord_t    in_ctrl_a_x = '0;
  coord_t    in_ctrl_a_y = '0;
  coord_t    in_ctrl_b_x = '0;
  coord_t    in_ctrl_b_y = '0;
  coord_t    in_end_x = '0;
  coord_t    in_end_y = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic [KIND_W-1:0] out_kind;
  coord_t    out_vertex_x;
  coord_t    out_vertex_y;
  logic      out_last;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  vertex_scoreboard sb = new();

  bezier_path_flattener_unit #(
    .SAMPLES(SAMPLES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_ctrl_a_x(in_ctrl_a_x),
    .in_ctrl_a_y(in_ctrl_a_y),
    .in_ctrl_b_x(in_ctrl_b_x),
    .in_ctrl_b_y(in_ctrl_b_y),
    .in_end_x(in_end_x),
    .in_end_y(in_end_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_vertex_x(out_vertex_x),
    .out_vertex_y(out_vertex_y),
    .out_last(out_last)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_vertex('{out_kind, out_vertex_x, out_vertex_y, out_last});
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return coord_t'($urandom);
      5, 6, 7: return coord_t'(int'($urandom_range(64)) - 32);
      8: return coord_t'(int'($urandom_range(4000)) - 2000);
      default: begin
        case ($urandom_range(3))
          0: return PT_MAX;
          1: return PT_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic path_req_t rand_req(req_code_t code);
    path_req_t r;
    r.req_type = code;
    r.ctrl_a_x = rand_coord();
    r.ctrl_a_y = rand_coord();
    r.ctrl_b_x = rand_coord();
    r.ctrl_b_y = rand_coord();
    r.end_x = rand_coord();
    r.end_y = rand_coord();
    return r;
  endfunction

  function automatic path_req_t mk_req(req_code_t code, coord_t ax, coord_t ay, coord_t bx,
                                       coord_t by, coord_t ex, coord_t ey);
    path_req_t r;
    r = '{code, ax, ay, bx, by, ex, ey};
    return r;
  endfunction

  function automatic req_code_t rand_segment();
    case ($urandom_range(2))
      0: return REQ_LINE;
      1: return REQ_QUAD;
      default: return REQ_CUBIC;
    endcase
  endfunction

  // one request through the input handshake, with random gaps ahead of it
  task automatic send_req(path_req_t r);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_req_type <= r.req_type;
    in_ctrl_a_x <= r.ctrl_a_x;
    in_ctrl_a_y <= r.ctrl_a_y;
    in_ctrl_b_x <= r.ctrl_b_x;
    in_ctrl_b_y <= r.ctrl_b_y;
    in_end_x <= r.end_x;
    in_end_y <= r.end_y;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  // hold off the sender until every expected vertex is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mostly well-formed contours, some noise and segments with no contour open
  task automatic run_random(int count);
    int sent;
    int pick;
    req_code_t code;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_req(rand_req(REQ_MOVE));
        sent++;
        repeat ($urandom_range(6, 1)) begin
          send_req(rand_req(rand_segment()));
          sent++;
        end
        if ($urandom_range(9) != 0) begin
          send_req(rand_req(REQ_CLOSE));
          sent++;
        end
      end else if (pick < 90) begin
        code = req_code_t'($urandom_range(REQ_LAST_UNUSED));
        send_req(rand_req(code));
        if (code < REQ_FIRST_UNUSED) sent++;
      end else begin
        send_req(rand_req(REQ_CLOSE));
        sent++;
        repeat ($urandom_range(3, 1)) begin
          send_req(rand_req(rand_segment()));
          sent++;
        end
      end
    end
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: sender idles lightly, receiver heavily
    snd_idle_pct = 25;
    rcv_idle_pct = 52;

    // directed: no contour open, extremes, every request, repeats and ties
    send_req(mk_req(REQ_CLOSE, PT_MAX, PT_MIN, PT_MAX, PT_MIN, PT_MAX, PT_MIN));
    send_req(mk_req(REQ_LINE, '0, '0, '0, '0, PT_MAX, PT_MIN));
    send_req(mk_req(REQ_QUAD, PT_MIN, PT_MAX, '0, '0, 24'sd5, -24'sd7));
    send_req(mk_req(REQ_MOVE, '0, '0, '0, '0, PT_MAX, PT_MIN));
    send_req(mk_req(REQ_LINE, '1, '1, '1, '1, PT_MIN, PT_MAX));
    send_req(mk_req(REQ_LINE, '0, '0, '0, '0, PT_MIN, PT_MAX));
    send_req(mk_req(REQ_QUAD, PT_MAX, PT_MAX, '0, '0, PT_MIN, PT_MIN));
    send_req(mk_req(REQ_CUBIC, PT_MIN, PT_MAX, PT_MAX, PT_MIN, '0, '0));
    // degenerate cubic at the current point: every sample repeats
    send_req(mk_req(REQ_CUBIC, '0, '0, '0, '0, '0, '0));
    // small curves hit rounding ties and repeated samples
    send_req(mk_req(REQ_QUAD, 24'sd1, -24'sd1, '0, '0, 24'sd3, -24'sd3));
    send_req(mk_req(REQ_CUBIC, -24'sd1, 24'sd2, 24'sd2, -24'sd1, 24'sd1, 24'sd1));
    // move while open closes the contour first
    send_req(mk_req(REQ_MOVE, '0, '0, '0, '0, -24'sd1, -24'sd1));
    send_req(mk_req(REQ_FIRST_UNUSED, PT_MAX, PT_MIN, PT_MAX, PT_MIN, PT_MAX, PT_MIN));
    send_req(mk_req(3'd6, '1, '1, '1, '1, '1, '1));
    send_req(mk_req(REQ_LAST_UNUSED, '0, '0, '0, '0, '0, '0));
    send_req(mk_req(REQ_LINE, '0, '0, '0, '0, '0, '0));
    send_req(mk_req(REQ_CLOSE, '0, '0, '0, '0, '0, '0));
    send_req(mk_req(REQ_CLOSE, '0, '0, '0, '0, '0, '0));
    send_req(mk_req(REQ_CUBIC, PT_MAX, PT_MIN, PT_MIN, PT_MAX, PT_MAX, PT_MAX));
    send_req(mk_req(REQ_MOVE, '0, '0, '0, '0, '0, '0));
    send_req(mk_req(REQ_QUAD, 24'sd100, PT_MAX, '0, '0, -24'sd100, PT_MIN));
    send_req(mk_req(REQ_CLOSE, '0, '0, '0, '0, '0, '0));

    run_random(160);
    wait_drained();

    // phase two: roles swapped
    snd_idle_pct = 52;
    rcv_idle_pct = 25;
    run_random(160);

    // phase three: no idling on either side
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(160);

    // drain
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftover();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
